/* design/trrs_pkg.sv */
// ----------------------------------------------------------------------------
// trrs_pkg
// Shared types and constants of the two-level round-robin scheduler.
// ----------------------------------------------------------------------------
package trrs_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int TIME_BITS   = 16;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int PCT_BITS    = 7;
    localparam int PROD_BITS   = TIME_BITS + PCT_BITS;

    localparam logic [3:0]          QUANTUM_RESET = 4'd3;
    localparam logic [PCT_BITS-1:0] SHARE_RESET   = 7'd80;
    localparam logic [PCT_BITS-1:0] PCT_SCALE     = 7'd100;

    localparam logic CFG_QUANTUM = 1'b0;
    localparam logic CFG_SHARE   = 1'b1;

    localparam logic OP_ARRIVAL  = 1'b0;
    localparam logic OP_TICK     = 1'b1;
    localparam logic CLASS_FG    = 1'b0;

    typedef enum logic [2:0] {
        STAT_IDLE   = 3'd0,
        STAT_FG_RAN = 3'd1,
        STAT_BG_RAN = 3'd2,
        STAT_ACCEPT = 3'd3,
        STAT_FULL   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_FG   = 2'd1,
        MODE_BG   = 2'd2
    } mode_t;

endpackage

/* design/two_level_round_robin_scheduler.sv */
// ----------------------------------------------------------------------------
// two_level_round_robin_scheduler
// Round-robin foreground table over a FCFS background queue, one tick per
// transaction, with a shared multiplier for the foreground share test.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  s_       | in        | s_valid / s_ready     | opcode, task_class, task_id, run_length
//  m_       | out       | m_valid / m_ready     | status, ran_id, finished, done_*
//  apb      | in        | psel/penable/pready   | paddr, pwdata, prdata
//
//  Tick: accept, busy*100, now*pct on the one multiplier, execute.
//  Arrival: accept, execute.
//  The result register frees the input side: the next transaction is taken
//  while a result still waits. Execute holds while the result is not taken.
//  Reset (aresetn low, synchronous) clears state, counters, pointers, mode,
//  configuration and m_valid; table entries and data registers hold no reset.
// ----------------------------------------------------------------------------
module two_level_round_robin_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic        s_task_class,
    input  logic [7:0]  s_task_id,
    input  logic [7:0]  s_run_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_ran_id,
    output logic        m_finished,
    output logic [15:0] m_done_arrival,
    output logic [7:0]  m_done_runtime,
    output logic [15:0] m_done_end,
    output logic [15:0] m_done_delay,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int D  = trrs_pkg::TABLE_DEPTH;
    localparam int TB = trrs_pkg::TIME_BITS;
    localparam int IB = trrs_pkg::IDX_BITS;
    localparam int CB = trrs_pkg::CNT_BITS;
    localparam int PB = trrs_pkg::PROD_BITS;
    localparam logic [CB-1:0] DEPTH_C = CB'(D);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL_BUSY, ST_MUL_NOW, ST_EXEC} state_t;

    state_t state_reg, state_next;

    logic [3:0]  quantum_reg;
    logic [6:0]  share_reg;

    logic        op_reg, op_next;
    logic        cls_reg, cls_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  len_reg, len_next;
    logic [PB-1:0] lhs_reg, lhs_next, rhs_reg, rhs_next;

    logic [TB-1:0] now_reg, now_next, busy_reg, busy_next;
    logic [7:0]    fg_ids_reg [D], fg_ids_next [D];
    logic [7:0]    fg_left_reg [D], fg_left_next [D];
    logic [TB-1:0] fg_arr_reg [D], fg_arr_next [D];
    logic [7:0]    fg_len_reg [D], fg_len_next [D];
    logic [CB-1:0] fg_count_reg, fg_count_next;
    logic [IB-1:0] fg_cursor_reg, fg_cursor_next;
    logic [3:0]    slice_reg, slice_next;
    logic [7:0]    bg_ids_reg [D], bg_ids_next [D];
    logic [TB-1:0] bg_arr_reg [D], bg_arr_next [D];
    logic [7:0]    bg_len_reg [D], bg_len_next [D];
    logic [IB-1:0] bg_head_reg, bg_head_next;
    logic [CB-1:0] bg_count_reg, bg_count_next;
    logic [7:0]    bg_left_reg, bg_left_next;
    trrs_pkg::mode_t mode_reg, mode_next;

    logic          m_valid_reg, m_valid_next;
    trrs_pkg::status_t m_status_reg, m_status_next;
    logic [7:0]    m_ran_id_reg, m_ran_id_next;
    logic          m_finished_reg, m_finished_next;
    logic [15:0]   m_arr_reg, m_arr_next, m_end_reg, m_end_next, m_delay_reg, m_delay_next;
    logic [7:0]    m_rt_reg, m_rt_next;

    // shared multiplier
    logic [TB-1:0] mul_a;
    logic [6:0]    mul_b;
    logic [PB-1:0] prod;

    assign mul_a = (state_reg == ST_MUL_BUSY) ? busy_reg : now_reg;
    assign mul_b = (state_reg == ST_MUL_BUSY) ? trrs_pkg::PCT_SCALE : share_reg;
    assign prod  = PB'(mul_a) * PB'(mul_b);

    // configuration
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == trrs_pkg::CFG_QUANTUM) ? {28'd0, quantum_reg}
                                                        : {25'd0, share_reg};

    assign s_ready = (state_reg == ST_IDLE);
    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        logic [7:0]    q;
        trrs_pkg::mode_t md;
        logic [IB-1:0] c;
        logic [3:0]    sl;
        logic [7:0]    bl;
        logic [TB-1:0] end_t;
        logic [TB-1:0] arr_t;
        logic [7:0]    ln_t;
        logic [IB-1:0] slot;
        logic [CB-1:0] cnt_m1;
        logic [IB:0]   cur_inc;

        q = (quantum_reg == 4'd0) ? 8'd1 : {4'd0, quantum_reg};
        md = mode_reg;
        c = 'x;
        sl = slice_reg;
        bl = bg_left_reg;
        end_t = now_reg + TB'(1);
        arr_t = '0;
        ln_t = '0;
        slot = bg_head_reg + bg_count_reg[IB-1:0];
        cnt_m1 = fg_count_reg - CB'(1);
        cur_inc = '0;

        state_next = state_reg;
        op_next = op_reg; cls_next = cls_reg; id_next = id_reg; len_next = len_reg;
        lhs_next = lhs_reg; rhs_next = rhs_reg;
        now_next = now_reg; busy_next = busy_reg;
        fg_ids_next = fg_ids_reg; fg_left_next = fg_left_reg;
        fg_arr_next = fg_arr_reg; fg_len_next = fg_len_reg;
        fg_count_next = fg_count_reg; fg_cursor_next = fg_cursor_reg;
        slice_next = slice_reg;
        bg_ids_next = bg_ids_reg; bg_arr_next = bg_arr_reg; bg_len_next = bg_len_reg;
        bg_head_next = bg_head_reg; bg_count_next = bg_count_reg;
        bg_left_next = bg_left_reg; mode_next = mode_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_status_next = m_status_reg; m_ran_id_next = m_ran_id_reg;
        m_finished_next = m_finished_reg; m_arr_next = m_arr_reg;
        m_rt_next = m_rt_reg; m_end_next = m_end_reg; m_delay_next = m_delay_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next  = s_opcode;
                    cls_next = s_task_class;
                    id_next  = s_task_id;
                    len_next = (s_run_length == 8'd0) ? 8'd1 : s_run_length;
                    state_next = (s_opcode == trrs_pkg::OP_TICK) ? ST_MUL_BUSY : ST_EXEC;
                end
            end
            ST_MUL_BUSY: begin
                lhs_next = prod;
                state_next = ST_MUL_NOW;
            end
            ST_MUL_NOW: begin
                rhs_next = prod;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_finished_next = 1'b0;
                    m_arr_next = '0; m_rt_next = '0; m_end_next = '0; m_delay_next = '0;
                    if (op_reg == trrs_pkg::OP_ARRIVAL) begin
                        m_ran_id_next = id_reg;
                        m_status_next = trrs_pkg::STAT_ACCEPT;
                        if (cls_reg == trrs_pkg::CLASS_FG) begin
                            if (fg_count_reg >= DEPTH_C) begin
                                m_status_next = trrs_pkg::STAT_FULL;
                            end else begin
                                fg_ids_next[fg_count_reg[IB-1:0]]  = id_reg;
                                fg_left_next[fg_count_reg[IB-1:0]] = len_reg;
                                fg_len_next[fg_count_reg[IB-1:0]]  = len_reg;
                                fg_arr_next[fg_count_reg[IB-1:0]]  = now_reg;
                                fg_count_next = fg_count_reg + CB'(1);
                            end
                        end else begin
                            if (bg_count_reg >= DEPTH_C) begin
                                m_status_next = trrs_pkg::STAT_FULL;
                            end else begin
                                bg_ids_next[slot] = id_reg;
                                bg_len_next[slot] = len_reg;
                                bg_arr_next[slot] = now_reg;
                                bg_count_next = bg_count_reg + CB'(1);
                            end
                        end
                    end else begin
                        // stale mode falls back to none, a stale cursor to the head
                        if ((md == trrs_pkg::MODE_FG && fg_count_reg == '0) ||
                            (md == trrs_pkg::MODE_BG && bg_count_reg == '0))
                            md = trrs_pkg::MODE_NONE;
                        c = (CB'(fg_cursor_reg) >= fg_count_reg) ? '0 : fg_cursor_reg;
                        if (md == trrs_pkg::MODE_NONE) begin
                            if (fg_count_reg != '0 && lhs_reg <= rhs_reg) begin
                                md = trrs_pkg::MODE_FG;
                                sl = '0;
                            end else if (bg_count_reg != '0) begin
                                md = trrs_pkg::MODE_BG;
                                bl = bg_len_reg[bg_head_reg];
                                if (bl == 8'd0) bl = 8'd1;
                            end
                        end
                        now_next = end_t;
                        m_ran_id_next = 8'd0;
                        case (md)
                            trrs_pkg::MODE_FG: begin
                                m_status_next = trrs_pkg::STAT_FG_RAN;
                                m_ran_id_next = fg_ids_reg[c];
                                busy_next = busy_reg + TB'(1);
                                mode_next = trrs_pkg::MODE_FG;
                                fg_cursor_next = c;
                                if (fg_left_reg[c] <= 8'd1) begin
                                    arr_t = fg_arr_reg[c];
                                    ln_t  = fg_len_reg[c];
                                    m_finished_next = 1'b1;
                                    for (int j = 0; j < D - 1; j++) begin
                                        if (IB'(j) >= c && CB'(j + 1) < fg_count_reg) begin
                                            fg_ids_next[j]  = fg_ids_reg[j+1];
                                            fg_left_next[j] = fg_left_reg[j+1];
                                            fg_arr_next[j]  = fg_arr_reg[j+1];
                                            fg_len_next[j]  = fg_len_reg[j+1];
                                        end
                                    end
                                    fg_count_next = cnt_m1;
                                    if (CB'(c) >= cnt_m1) fg_cursor_next = '0;
                                    slice_next = '0;
                                    mode_next = trrs_pkg::MODE_NONE;
                                end else begin
                                    fg_left_next[c] = fg_left_reg[c] - 8'd1;
                                    sl = sl + 4'd1;
                                    slice_next = sl;
                                    if ({4'd0, sl} >= q) begin
                                        cur_inc = {1'b0, c} + (IB+1)'(1);
                                        fg_cursor_next = (CB'(cur_inc) >= fg_count_reg)
                                                         ? '0 : cur_inc[IB-1:0];
                                        slice_next = '0;
                                        mode_next = trrs_pkg::MODE_NONE;
                                    end
                                end
                            end
                            trrs_pkg::MODE_BG: begin
                                m_status_next = trrs_pkg::STAT_BG_RAN;
                                m_ran_id_next = bg_ids_reg[bg_head_reg];
                                mode_next = trrs_pkg::MODE_BG;
                                fg_cursor_next = c;
                                if (bl != 8'd0) bl = bl - 8'd1;
                                bg_left_next = bl;
                                if (bl == 8'd0) begin
                                    arr_t = bg_arr_reg[bg_head_reg];
                                    ln_t  = (bg_len_reg[bg_head_reg] == 8'd0)
                                            ? 8'd1 : bg_len_reg[bg_head_reg];
                                    m_finished_next = 1'b1;
                                    bg_head_next = bg_head_reg + IB'(1);
                                    bg_count_next = bg_count_reg - CB'(1);
                                    mode_next = trrs_pkg::MODE_NONE;
                                end
                            end
                            default: begin
                                m_status_next = trrs_pkg::STAT_IDLE;
                                fg_cursor_next = '0;
                                mode_next = trrs_pkg::MODE_NONE;
                            end
                        endcase
                        if (m_finished_next) begin
                            m_arr_next   = 16'(arr_t);
                            m_rt_next    = ln_t;
                            m_end_next   = 16'(end_t);
                            m_delay_next = 16'(end_t - arr_t - TB'(ln_t));
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            quantum_reg   <= trrs_pkg::QUANTUM_RESET;
            share_reg     <= trrs_pkg::SHARE_RESET;
            now_reg       <= '0;
            busy_reg      <= '0;
            fg_count_reg  <= '0;
            fg_cursor_reg <= '0;
            slice_reg     <= '0;
            bg_head_reg   <= '0;
            bg_count_reg  <= '0;
            bg_left_reg   <= '0;
            mode_reg      <= trrs_pkg::MODE_NONE;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_wr && paddr[2] == trrs_pkg::CFG_QUANTUM) quantum_reg <= pwdata[3:0];
            if (cfg_wr && paddr[2] == trrs_pkg::CFG_SHARE)   share_reg   <= pwdata[6:0];
            now_reg       <= now_next;
            busy_reg      <= busy_next;
            fg_count_reg  <= fg_count_next;
            fg_cursor_reg <= fg_cursor_next;
            slice_reg     <= slice_next;
            bg_head_reg   <= bg_head_next;
            bg_count_reg  <= bg_count_next;
            bg_left_reg   <= bg_left_next;
            mode_reg      <= mode_next;
            m_valid_reg   <= m_valid_next;
        end
        op_reg <= op_next; cls_reg <= cls_next; id_reg <= id_next; len_reg <= len_next;
        lhs_reg <= lhs_next; rhs_reg <= rhs_next;
        fg_ids_reg <= fg_ids_next; fg_left_reg <= fg_left_next;
        fg_arr_reg <= fg_arr_next; fg_len_reg <= fg_len_next;
        bg_ids_reg <= bg_ids_next; bg_arr_reg <= bg_arr_next; bg_len_reg <= bg_len_next;
        m_status_reg <= m_status_next; m_ran_id_reg <= m_ran_id_next;
        m_finished_reg <= m_finished_next; m_arr_reg <= m_arr_next;
        m_rt_reg <= m_rt_next; m_end_reg <= m_end_next; m_delay_reg <= m_delay_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_ran_id       = m_ran_id_reg;
    assign m_finished     = m_finished_reg;
    assign m_done_arrival = m_arr_reg;
    assign m_done_runtime = m_rt_reg;
    assign m_done_end     = m_end_reg;
    assign m_done_delay   = m_delay_reg;

    a_fg_count: assert property (@(posedge aclk) disable iff (!aresetn)
        fg_count_reg <= DEPTH_C) else $error("fg table overflow");
    a_bg_count: assert property (@(posedge aclk) disable iff (!aresetn)
        bg_count_reg <= DEPTH_C) else $error("bg queue overflow");
    a_fin_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_finished_reg) |->
        (m_status_reg == trrs_pkg::STAT_FG_RAN || m_status_reg == trrs_pkg::STAT_BG_RAN))
        else $error("completion on non-run result");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && m_valid_reg && !m_ready) |=> state_reg == ST_EXEC)
        else $error("result overwritten while stalled");

endmodule

/* verif/two_level_round_robin_scheduler_test.sv */
// ----------------------------------------------------------------------------
// two_level_round_robin_scheduler_test
// Drives arrivals and ticks into the scheduler, predicts every result from a
// behavioral copy of the foreground/background tables, and checks each field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_level_round_robin_scheduler_test;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  ran_id;
        logic        finished;
        logic [15:0] arrival;
        logic [7:0]  runtime;
        logic [15:0] end_t;
        logic [15:0] delay;
    } sched_result_t;

    localparam int EXP_SLOTS = 64;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = 1'b0;
    logic        s_task_class = 1'b0;
    logic [7:0]  s_task_id = 8'd0;
    logic [7:0]  s_run_length = 8'd1;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [7:0]  m_ran_id;
    logic        m_finished;
    logic [15:0] m_done_arrival;
    logic [7:0]  m_done_runtime;
    logic [15:0] m_done_end;
    logic [15:0] m_done_delay;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    two_level_round_robin_scheduler dut (.*);

    always #4 aclk = ~aclk;

    // predictor state
    logic [3:0]  quantum;
    logic [6:0]  share_pct;
    logic [15:0] now_t, fg_busy;
    logic [7:0]  fg_id[trrs_pkg::TABLE_DEPTH], fg_rem[trrs_pkg::TABLE_DEPTH];
    logic [7:0]  fg_len[trrs_pkg::TABLE_DEPTH];
    logic [15:0] fg_arr[trrs_pkg::TABLE_DEPTH];
    int          fg_cnt, fg_cur, slice;
    logic [7:0]  bg_id[trrs_pkg::TABLE_DEPTH], bg_len[trrs_pkg::TABLE_DEPTH];
    logic [15:0] bg_arr[trrs_pkg::TABLE_DEPTH];
    int          bg_hd, bg_cnt;
    logic [7:0]  bg_rem;
    trrs_pkg::mode_t mode;

    // expected results in order, written by the sender and read by the checker
    sched_result_t exp_ring[EXP_SLOTS];
    int exp_wr = 0, exp_rd = 0;
    int errors = 0;
    int n_items = 0, n_results = 0, n_done = 0, n_full = 0;
    bit hold_off = 1'b0;

    function automatic sched_result_t done_fields(sched_result_t r, logic [15:0] arr,
                                                  logic [7:0] len);
        r.finished = 1'b1;
        r.arrival  = arr;
        r.runtime  = len;
        r.end_t    = now_t;
        r.delay    = now_t - arr - 16'(len);
        return r;
    endfunction

    function automatic sched_result_t schedule_step(logic op, logic cls, logic [7:0] id,
                                                    logic [7:0] len_in);
        sched_result_t r;
        logic [7:0]  len;
        int          q, c, slot;
        logic [31:0] lhs, rhs;
        r = '0;
        len = (len_in == 0) ? 8'd1 : len_in;
        q = (quantum == 0) ? 1 : quantum;
        if (op == trrs_pkg::OP_ARRIVAL) begin
            r.ran_id = id;
            if (cls == trrs_pkg::CLASS_FG) begin
                if (fg_cnt >= trrs_pkg::TABLE_DEPTH) begin
                    r.status = trrs_pkg::STAT_FULL;
                    return r;
                end
                fg_id[fg_cnt] = id; fg_rem[fg_cnt] = len;
                fg_len[fg_cnt] = len; fg_arr[fg_cnt] = now_t;
                fg_cnt++;
            end else begin
                if (bg_cnt >= trrs_pkg::TABLE_DEPTH) begin
                    r.status = trrs_pkg::STAT_FULL;
                    return r;
                end
                slot = (bg_hd + bg_cnt) % trrs_pkg::TABLE_DEPTH;
                bg_id[slot] = id; bg_len[slot] = len; bg_arr[slot] = now_t;
                bg_cnt++;
            end
            r.status = trrs_pkg::STAT_ACCEPT;
            return r;
        end
        if ((mode == trrs_pkg::MODE_FG && fg_cnt == 0) ||
            (mode == trrs_pkg::MODE_BG && bg_cnt == 0))
            mode = trrs_pkg::MODE_NONE;
        if (fg_cur >= fg_cnt) fg_cur = 0;
        if (mode == trrs_pkg::MODE_NONE) begin
            lhs = 32'(fg_busy) * 100;
            rhs = 32'(now_t) * 32'(share_pct);
            if (fg_cnt > 0 && lhs <= rhs) begin
                mode = trrs_pkg::MODE_FG;
                slice = 0;
            end else if (bg_cnt > 0) begin
                mode = trrs_pkg::MODE_BG;
                bg_rem = bg_len[bg_hd];
            end else begin
                now_t++;
                fg_cur = 0;
                r.status = trrs_pkg::STAT_IDLE;
                return r;
            end
        end
        if (mode == trrs_pkg::MODE_FG) begin
            c = fg_cur;
            r.status = trrs_pkg::STAT_FG_RAN;
            r.ran_id = fg_id[c];
            now_t++;
            fg_busy++;
            if (fg_rem[c] <= 1) begin
                r = done_fields(r, fg_arr[c], fg_len[c]);
                for (int j = c; j + 1 < fg_cnt; j++) begin
                    fg_id[j] = fg_id[j+1]; fg_rem[j] = fg_rem[j+1];
                    fg_arr[j] = fg_arr[j+1]; fg_len[j] = fg_len[j+1];
                end
                fg_cnt--;
                if (fg_cur >= fg_cnt) fg_cur = 0;
                slice = 0;
                mode = trrs_pkg::MODE_NONE;
            end else begin
                fg_rem[c]--;
                slice++;
                if (slice >= q) begin
                    fg_cur++;
                    if (fg_cur >= fg_cnt) fg_cur = 0;
                    slice = 0;
                    mode = trrs_pkg::MODE_NONE;
                end
            end
            return r;
        end
        r.status = trrs_pkg::STAT_BG_RAN;
        r.ran_id = bg_id[bg_hd];
        now_t++;
        if (bg_rem > 0) bg_rem--;
        if (bg_rem == 0) begin
            r = done_fields(r, bg_arr[bg_hd], bg_len[bg_hd]);
            bg_hd = (bg_hd + 1) % trrs_pkg::TABLE_DEPTH;
            bg_cnt--;
            mode = trrs_pkg::MODE_NONE;
        end
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic op, logic cls, logic [7:0] id, logic [7:0] len,
                             bit gaps = 1'b1);
        int g;
        g = gaps ? gap_len() : 0;
        // valid was dropped at the last edge; the block is busy for that cycle anyway
        @(posedge aclk);
        repeat (g) @(posedge aclk);
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_task_class <= cls;
        s_task_id    <= id;
        s_run_length <= len;
        exp_ring[exp_wr % EXP_SLOTS] = schedule_step(op, cls, id, len);
        exp_wr++;
        n_items++;
        do @(posedge aclk); while (!(s_ready === 1'b1));
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (exp_wr != exp_rd && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        // a tick may still be in flight behind the last result
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!(pready === 1'b1));
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'(int'(trrs_pkg::CFG_QUANTUM) * 4)) quantum = value[3:0];
        else share_pct = value[6:0];
    endtask

    task automatic configure(logic [3:0] q, logic [6:0] pct);
        drain();
        write_reg(3'(int'(trrs_pkg::CFG_QUANTUM) * 4), 32'(q));
        write_reg(3'(int'(trrs_pkg::CFG_SHARE) * 4), 32'(pct));
    endtask

    task automatic tick(bit gaps = 1'b1);
        send_item(trrs_pkg::OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), gaps);
    endtask

    task automatic test_directed();
        send_item(trrs_pkg::OP_TICK, 1'b0, 8'hff, 8'h00);        // idle tick
        send_item(trrs_pkg::OP_ARRIVAL, 1'b0, 8'h00, 8'h00);     // zero length
        send_item(trrs_pkg::OP_ARRIVAL, 1'b0, 8'hff, 8'hff);
        send_item(trrs_pkg::OP_ARRIVAL, 1'b1, 8'h5a, 8'h02);
        send_item(trrs_pkg::OP_ARRIVAL, 1'b1, 8'ha5, 8'h01);
        repeat (12) tick();
    endtask

    task automatic test_full_tables();
        for (int i = 0; i < 18; i++)
            send_item(trrs_pkg::OP_ARRIVAL, 1'b0, 8'(i), 8'(1 + i % 4));
        for (int i = 0; i < 18; i++)
            send_item(trrs_pkg::OP_ARRIVAL, 1'b1, 8'(i + 100), 8'(1 + i % 3));
        while (fg_cnt + bg_cnt > 0) tick();
    endtask

    task automatic test_random(int total);
        int k;
        k = 0;
        while (k < total) begin
            // random bursts: one to five arrivals, then two to twenty ticks
            repeat ($urandom_range(1, 5)) begin
                send_item(trrs_pkg::OP_ARRIVAL, 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)),
                          ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 12)));
                k++;
            end
            repeat ($urandom_range(2, 20)) begin
                tick();
                k++;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(trrs_pkg::OP_ARRIVAL, 1'(i % 2), 8'(i), 8'd2, 1'b0);
        repeat (30) tick(1'b0);
        hold_off = 1'b0;
    endtask

    // result sink with random stalls and one long hold
    initial begin
        int g;
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            g = gap_len();
            if (g != 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        sched_result_t got, exp_r;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_status, m_ran_id, m_finished, m_done_arrival, m_done_runtime,
                    m_done_end, m_done_delay};
            n_results++;
            if (exp_wr == exp_rd) begin
                $display("%0t: unexpected transaction %p", $time, got);
                errors++;
            end else begin
                exp_r = exp_ring[exp_rd % EXP_SLOTS];
                exp_rd++;
                if (exp_r.finished) n_done++;
                if (exp_r.status == trrs_pkg::STAT_FULL) n_full++;
                if (got !== exp_r) begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        quantum = trrs_pkg::QUANTUM_RESET; share_pct = trrs_pkg::SHARE_RESET;
        now_t = '0; fg_busy = '0; fg_cnt = 0; fg_cur = 0; slice = 0;
        bg_hd = 0; bg_cnt = 0; bg_rem = '0; mode = trrs_pkg::MODE_NONE;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_tables();
        configure(4'd1, 7'd0);
        test_random(400);
        configure(4'd15, 7'd100);
        test_random(400);
        configure(4'd0, 7'd127);
        test_random(300);
        configure(4'd2, 7'd50);
        test_backpressure();
        test_random(600);
        drain();
        if (exp_wr != exp_rd) errors++;
        $display("Covered %0d items, %0d results, %0d completions, %0d full drops.",
                 n_items, n_results, n_done, n_full);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
design/trrs_pkg.sv
design/two_level_round_robin_scheduler.sv
verif/two_level_round_robin_scheduler_test.sv
